// ===== design/weighted_credit_scheduler_defines.svh =====
// Assertion macros shared by the scheduler checker.
`ifndef WEIGHTED_CREDIT_SCHEDULER_DEFINES_SVH
`define WEIGHTED_CREDIT_SCHEDULER_DEFINES_SVH
// An implication checked at every clock edge outside reset.
`define WCS_ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// A next-cycle implication checked outside reset.
`define WCS_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

// ===== design/wcs_pkg.sv =====
// Shared types and constants of the weighted credit scheduler.
`timescale 1ns / 1ps
package wcs_pkg;
    localparam int NUM_USERS = 8;
    localparam int CREDIT_W = 32;
    localparam int WEIGHT_W = 16;
    localparam int TOTAL_W = 19;
    localparam int TICK_W = 32;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    localparam logic [2:0] OP_SET_WEIGHT = 3'd0;
    localparam logic [2:0] OP_SET_HEAD = 3'd1;
    localparam logic [2:0] OP_INIT = 3'd2;
    localparam logic [2:0] OP_REPLENISH = 3'd3;
    localparam logic [2:0] OP_CHARGE = 3'd4;
    localparam logic [2:0] OP_COMPENSATE = 3'd5;
    localparam logic [2:0] OP_SCHEDULE = 3'd6;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_IDLE = 2'd2;
    localparam logic [1:0] ST_NOWEIGHT = 2'd3;

    localparam logic [1:0] REG_CREDIT_POOL = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_MODE = 2'd2;

    // Request and reply of the shared divider.
    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [47:0] quotient;
    } div_rsp_t;
endpackage

// ===== design/wcs_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wcs_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  wcs_pkg::div_req_t req,
    output wcs_pkg::div_rsp_t rsp
);
    import wcs_pkg::*;

    logic [47:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        run_reg;
    logic        done_reg;
    logic [32:0] trial;

    // One shift-and-subtract step per cycle.
    assign trial = {rem_reg, quo_reg[47]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'd48;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    run_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= 32'(trial - {1'b0, dvs_reg});
                quo_reg <= {quo_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[46:0], 1'b0};
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

// ===== design/weighted_credit_scheduler.sv =====
// Top level of the weighted credit scheduler: sequencer, user tables and register port.
//
// Usage: pulse start while busy is low with one command word (opcode and
// operands). The block raises busy and walks its user table under a small
// sequencer; one shared 48-by-32 bit serial divider serves both the credit
// shares of init and replenish and the period numbers of schedule.
// Steps: set_head, unknown opcodes, an out-of-range user and a zero weight
// total go straight to the done state; charge and compensate add one update
// step; set_weight re-sums the total one user a cycle; init and replenish run
// one 48-step division per user. Schedule runs the max-credit pass when mode
// bit 0 is set and, if that is skipped or finds no user, then either the
// work-conserving pass (mode bit 1, up to two scans) or the period pass (one
// division for now, then one per user).
// One command is in work at a time; the next is taken at the edge that takes
// the result. The result word appears on status, chosen_user and credit_out for
// one cycle with done high; the receiver cannot stall it.
// The user writes configuration over the APB port only while the block is idle; the block does not enforce it.
// Reset clears weights, credits, head valid bits and the weight total and
// restores the registers to credit pool 1000, period_length 1000, mode 1.
`timescale 1ns / 1ps
module weighted_credit_scheduler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [2:0]  user_index,
    input  logic [15:0] weight_value,
    input  logic        head_present,
    input  logic [31:0] head_arrival,
    input  logic signed [31:0] amount,
    input  logic [31:0] now_tick,
    output logic        done,
    output logic [1:0]  status,
    output logic [2:0]  chosen_user,
    output logic signed [31:0] credit_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import wcs_pkg::*;

    localparam int UW = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
    localparam int CW = $clog2(NUM_USERS + 1);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_SUM    = 9'b000000010,
        S_SHARE  = 9'b000000100,
        S_SHWAIT = 9'b000001000,
        S_MAXC   = 9'b000010000,
        S_NOWDIV = 9'b000100000,
        S_NOWWT  = 9'b001000000,
        S_SCAN   = 9'b010000000,
        S_DONE   = 9'b100000000
    } state_t;

    state_t state_reg;
    logic [19:0] credit_pool_reg;
    logic [31:0] period_reg;
    logic [1:0]  mode_reg;

    logic signed [31:0] credit_reg [NUM_USERS];
    logic [15:0] weight_reg [NUM_USERS];
    logic [NUM_USERS-1:0] hv_reg;
    logic [31:0] arr_reg [NUM_USERS];
    logic [TOTAL_W-1:0] total_reg;

    logic [2:0]  op_reg;
    logic [2:0]  idx_reg;
    logic signed [31:0] amt_reg;
    logic [31:0] now_reg;
    logic [CW-1:0] cnt_reg;
    logic [TOTAL_W-1:0] sum_reg;
    logic        divgo_reg;
    logic [31:0] nowp_reg;
    logic        pass_reg;  // 0 first search of this pass, 1 fallback
    logic        found_reg;
    logic        any_reg;
    logic [UW-1:0] pick_reg;
    logic signed [31:0] best_reg;
    logic [1:0]  st_reg;
    logic [2:0]  cu_reg;
    logic signed [31:0] co_reg;
    logic        done_reg;

    div_req_t dreq;
    div_rsp_t drsp;
    wcs_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    logic [UW-1:0] ui;
    logic signed [31:0] cr;
    logic [31:0] ar, parr;
    logic signed [32:0] cadd;
    logic [31:0] per;
    logic [TOTAL_W:0] sum_wide;
    logic [35:0] ic_w;
    logic hit, arrived;
    logic max_take, per_take;
    logic signed [32:0] share_sum;
    logic [31:0] share;

    assign ui = cnt_reg[UW-1:0];
    assign cr = credit_reg[ui];
    assign ar = arr_reg[ui];
    assign parr = arr_reg[pick_reg];
    assign arrived = ar <= now_reg;
    assign per = (period_reg == 32'd0) ? 32'd1 : period_reg;
    assign sum_wide = {1'b0, sum_reg} + {{(TOTAL_W-15){1'b0}}, weight_reg[ui]};
    assign ic_w = {16'd0, credit_pool_reg} * {20'd0, weight_reg[ui]};
    assign share = drsp.quotient[31:0];
    assign share_sum = {cr[31], cr} + {1'b0, share};

    // Divider request: share numerator, or the now tick or an arrival over the period.
    always_comb
    begin
        dreq.start = divgo_reg;
        dreq.dividend = {4'd0, ic_w[35:0], 8'd0};
        dreq.divisor = {{(32-TOTAL_W){1'b0}}, total_reg};
        if (op_reg == OP_SCHEDULE)
        begin
            dreq.dividend = {16'd0, (state_reg == S_NOWWT) ? now_reg : ar};
            dreq.divisor = per;
        end
    end

    // Signed add or subtract for charge and compensate, saturated.
    always_comb
    begin
        if (op_reg == OP_CHARGE)
            cadd = {credit_reg[idx_reg[UW-1:0]][31], credit_reg[idx_reg[UW-1:0]]}
                   - {amt_reg[31], amt_reg};
        else
            cadd = {credit_reg[idx_reg[UW-1:0]][31], credit_reg[idx_reg[UW-1:0]]}
                   + {amt_reg[31], amt_reg};
    end

    function automatic logic signed [31:0] sat(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh80000000 : 32'sh7fffffff;
        return v[31:0];
    endfunction

    // Scan step hit test for the work-conserving search.
    assign hit = hv_reg[ui] && (pass_reg || arrived)
                 && (!found_reg || ar < parr);

    // Max-credit step: a larger positive credit, or an equal one that arrived earlier.
    assign max_take = hv_reg[ui] && arrived
                      && (cr > best_reg || (found_reg && cr == best_reg && ar < parr));

    // Period step: positive credit, same period as now, earliest arrival so far.
    assign per_take = hv_reg[ui] && !cr[31] && cr != 0 && share == nowp_reg
                      && (!found_reg || ar < parr);

    // Register port.
    assign pready = 1'b1;
    always_comb
    begin
        unique case (paddr[3:2])
            REG_CREDIT_POOL: prdata = {12'd0, credit_pool_reg};
            REG_PERIOD:      prdata = period_reg;
            REG_MODE:        prdata = {30'd0, mode_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_pool_reg <= 20'd1000;
            period_reg <= 32'd1000;
            mode_reg <= 2'd1;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr[3:2])
                REG_CREDIT_POOL: credit_pool_reg <= pwdata[19:0];
                REG_PERIOD:      period_reg <= pwdata;
                REG_MODE:        mode_reg <= pwdata[1:0];
                default:         ;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign status = st_reg;
    assign chosen_user = cu_reg;
    assign credit_out = co_reg;

    // Sequencer and table updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            hv_reg <= '0;
            total_reg <= '0;
            done_reg <= 1'b0;
            divgo_reg <= 1'b0;
            op_reg <= '0;
            idx_reg <= '0;
            amt_reg <= '0;
            now_reg <= '0;
            cnt_reg <= '0;
            sum_reg <= '0;
            nowp_reg <= '0;
            pass_reg <= 1'b0;
            found_reg <= 1'b0;
            any_reg <= 1'b0;
            pick_reg <= '0;
            best_reg <= '0;
            st_reg <= ST_OK;
            cu_reg <= '0;
            co_reg <= '0;
            for (int i = 0; i < NUM_USERS; i++)
            begin
                credit_reg[i] <= '0;
                weight_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            divgo_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg <= opcode;
                        idx_reg <= user_index;
                        amt_reg <= amount;
                        now_reg <= now_tick;
                        cnt_reg <= '0;
                        sum_reg <= '0;
                        found_reg <= 1'b0;
                        any_reg <= 1'b0;
                        pass_reg <= 1'b0;
                        pick_reg <= '0;
                        best_reg <= '0;
                        st_reg <= ST_OK;
                        cu_reg <= 3'd0;
                        co_reg <= '0;
                        state_reg <= S_DONE;
                        unique case (opcode)
                            OP_SET_WEIGHT:
                            begin
                                cu_reg <= user_index;
                                if ({1'b0, user_index} < 4'(NUM_USERS))
                                begin
                                    weight_reg[user_index[UW-1:0]] <= weight_value;
                                    state_reg <= S_SUM;
                                end
                            end
                            OP_SET_HEAD:
                            begin
                                cu_reg <= user_index;
                                if ({1'b0, user_index} < 4'(NUM_USERS))
                                begin
                                    hv_reg[user_index[UW-1:0]] <= head_present;
                                    arr_reg[user_index[UW-1:0]] <= head_arrival;
                                end
                            end
                            OP_INIT, OP_REPLENISH:
                            begin
                                if (total_reg == '0)
                                    st_reg <= ST_NOWEIGHT;
                                else
                                begin
                                    divgo_reg <= 1'b1;
                                    state_reg <= S_SHARE;
                                end
                            end
                            OP_CHARGE, OP_COMPENSATE:
                            begin
                                cu_reg <= user_index;
                                if ({1'b0, user_index} < 4'(NUM_USERS))
                                    state_reg <= S_SUM;
                            end
                            OP_SCHEDULE:
                                state_reg <= mode_reg[0] ? S_MAXC : S_NOWDIV;
                            default: ;
                        endcase
                    end
                end
                S_SUM:
                begin
                    if (op_reg == OP_CHARGE || op_reg == OP_COMPENSATE)
                    begin
                        credit_reg[idx_reg[UW-1:0]] <= sat(cadd);
                        co_reg <= sat(cadd);
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        sum_reg <= sum_wide[TOTAL_W] ? TOTAL_MAX : sum_wide[TOTAL_W-1:0];
                        if (cnt_reg == CW'(NUM_USERS - 1))
                        begin
                            total_reg <= sum_wide[TOTAL_W] ? TOTAL_MAX
                                         : sum_wide[TOTAL_W-1:0];
                            state_reg <= S_DONE;
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_SHARE:
                    state_reg <= S_SHWAIT;
                S_SHWAIT:
                begin
                    if (drsp.done)
                    begin
                        if (op_reg == OP_REPLENISH && cr[31])
                            credit_reg[ui] <= sat(share_sum);
                        else
                            credit_reg[ui] <= share;
                        if (cnt_reg == CW'(NUM_USERS - 1))
                            state_reg <= S_DONE;
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            divgo_reg <= 1'b1;
                            state_reg <= S_SHARE;
                        end
                    end
                end
                S_MAXC:
                begin
                    if (max_take)
                    begin
                        best_reg <= cr;
                        pick_reg <= ui;
                        found_reg <= 1'b1;
                    end
                    if (cnt_reg == CW'(NUM_USERS - 1))
                    begin
                        cnt_reg <= '0;
                        if (found_reg || max_take)
                        begin
                            cu_reg <= 3'(max_take ? ui : pick_reg);
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            found_reg <= 1'b0;
                            state_reg <= S_NOWDIV;
                        end
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_NOWDIV:
                begin
                    if (mode_reg[1])
                        state_reg <= S_SCAN;
                    else
                    begin
                        divgo_reg <= 1'b1;
                        state_reg <= S_NOWWT;
                    end
                end
                S_NOWWT:
                begin
                    if (drsp.done)
                    begin
                        nowp_reg <= share;
                        divgo_reg <= 1'b1;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (mode_reg[1])
                    begin
                        // Work-conserving: arrived heads first, then any head.
                        if (hit)
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= ui;
                        end
                        if (cnt_reg == CW'(NUM_USERS - 1))
                        begin
                            cnt_reg <= '0;
                            if (found_reg || hit)
                            begin
                                cu_reg <= 3'(hit ? ui : pick_reg);
                                state_reg <= S_DONE;
                            end
                            else if (!pass_reg)
                                pass_reg <= 1'b1;
                            else
                            begin
                                st_reg <= ST_EMPTY;
                                state_reg <= S_DONE;
                            end
                        end
                        else
                            cnt_reg <= cnt_reg + 1'b1;
                    end
                    else if (drsp.done)
                    begin
                        // Period pass: one arrival division per user.
                        if (hv_reg[ui])
                            any_reg <= 1'b1;
                        if (per_take)
                        begin
                            found_reg <= 1'b1;
                            pick_reg <= ui;
                        end
                        if (cnt_reg == CW'(NUM_USERS - 1))
                        begin
                            state_reg <= S_DONE;
                            if (found_reg || per_take)
                                cu_reg <= 3'(per_take ? ui : pick_reg);
                            else
                                st_reg <= (any_reg || hv_reg[ui]) ? ST_IDLE : ST_EMPTY;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                            divgo_reg <= 1'b1;
                        end
                    end
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== design/wcs_checker.sv =====
// Port-level checker for the weighted credit scheduler, bound to the top level.
`timescale 1ns / 1ps
`include "weighted_credit_scheduler_defines.svh"
module wcs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic signed [31:0] credit_out,
    input logic        pready
);
    import wcs_pkg::*;

    // A command taken makes the block busy.
    `WCS_ASSERT_NEXT(a_busy, clk, rst_n, start && !busy, busy)
    // A result word ends the command.
    `WCS_ASSERT_IMPL(a_done_free, clk, rst_n, done, !busy)
    // The done strobe lasts one cycle.
    `WCS_ASSERT_NEXT(a_done_pulse, clk, rst_n, done, !done)
    // Register port never waits.
    `WCS_ASSERT_IMPL(a_ready, clk, rst_n, 1'b1, pready)
    // Only a successful word can carry a credit.
    `WCS_ASSERT_IMPL(a_credit_ok, clk, rst_n, done && status != ST_OK, credit_out == 32'sd0)
endmodule

bind weighted_credit_scheduler wcs_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .status(status), .credit_out(credit_out), .pready(pready)
);
